// File: hw/rtl/assert_macros.svh
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define OTB_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define OTB_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: hw/rtl/otb_pkg.sv
// Package with the types, codes and sizes of the one-shot timer bank.
`timescale 1ns / 1ps
package otb_pkg;

  localparam int NUM_TIMERS  = 16;
  localparam int COUNT_BITS  = 16;
  localparam int PERIOD_BITS = 16;
  localparam int ID_BITS     = 4;
  localparam int IDX_W       = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int CMP_W       = (COUNT_BITS > PERIOD_BITS) ? COUNT_BITS : PERIOD_BITS;

  typedef enum logic [2:0] {
    ACT_CREATE = 3'd0,
    ACT_SET    = 3'd1,
    ACT_QUERY  = 3'd2,
    ACT_DELETE = 3'd3,
    ACT_RESET  = 3'd4,
    ACT_TICK   = 3'd5
  } action_e;

  typedef enum logic [1:0] {
    KIND_STATUS  = 2'd0,
    KIND_STATE   = 2'd1,
    KIND_EXPIRED = 2'd2,
    KIND_DONE    = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    TS_STOPPED = 2'd0,
    TS_RUNNING = 2'd1,
    TS_INVALID = 2'd2
  } tstate_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMD,
    ST_SCAN,
    ST_DONE
  } state_e;

  // One timer entry as it sits in the RAM.
  typedef struct packed {
    logic                   exists;
    logic                   running;
    logic [COUNT_BITS-1:0]  count;
    logic [PERIOD_BITS-1:0] period;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

// File: hw/rtl/otb_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module otb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                      clk_i,
  input  logic                                      we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                          wdata_i,
  input  logic                                      re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                          rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port; data holds until the next read.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/one_shot_timer_bank_core.sv
// Top level of the one-shot timer bank: command sequencer around the entry RAM.
`timescale 1ns / 1ps
// One-shot timer bank. Every timer entry (exists, running, count, period) lives in
// one RAM word; entries never written read as all zero through a valid bit per entry,
// so no clearing pass follows reset. The block handles one item at a time and holds
// in_stall_o high while it works. A create, set state, query, delete or reset item
// is accepted with the RAM read, then updates the entry where needed and emits its
// result. A tick item reads one entry per cycle through the single RAM read port,
// except while an expiry item waits on a stalled output; it emits one expiry item
// for each timer that runs out and then a closing tick-done item marked last.
module one_shot_timer_bank_core
  import otb_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [2:0]             action_i,
  input  logic [ID_BITS-1:0]     timer_id_i,
  input  logic [PERIOD_BITS-1:0] period_i,
  input  logic                   new_state_i,
  input  logic                   has_handler_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [1:0]             kind_o,
  output logic                   ok_o,
  output logic [1:0]             timer_state_o,
  output logic [ID_BITS-1:0]     timer_id_res_o,
  output logic                   last_o
);

  state_e state_q, state_d;

  // Latched item.
  logic [2:0]             act_q;
  logic [ID_BITS-1:0]     id_q;
  logic [PERIOD_BITS-1:0] per_q;
  logic                   nst_q;
  logic                   hh_q;

  logic [IDX_W-1:0]      scan_q, scan_d;
  logic [IDX_W-1:0]      rd_idx_q;
  logic [NUM_TIMERS-1:0] valid_q;

  // RAM port signals.
  logic             ram_we, ram_re;
  logic [IDX_W-1:0] ram_waddr, ram_raddr;
  entry_t           ram_wdata;
  logic [ENTRY_W-1:0] ram_rdata;

  // Output register.
  logic               out_valid_q;
  logic [1:0]         kind_q;
  logic               ok_q;
  logic [1:0]         tstate_q;
  logic [ID_BITS-1:0] rid_q;
  logic               last_q;
  logic               out_load;
  logic [1:0]         kind_d;
  logic               ok_d;
  logic [1:0]         tstate_d;
  logic [ID_BITS-1:0] rid_d;
  logic               last_d;
  logic               out_free;

  logic                  in_accept;
  entry_t                ent;
  logic                  inb;
  logic                  ex;
  logic [COUNT_BITS-1:0] cnt_inc;
  logic                  expire;
  logic                  active;
  logic                  step_ok;
  logic                  scan_last;

  otb_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (NUM_TIMERS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  // Entry view: never-written entries read as reset value.
  assign ent = valid_q[rd_idx_q] ? entry_t'(ram_rdata) : '0;

  assign inb = (32'(id_q) < 32'(NUM_TIMERS));
  assign ex  = inb && ent.exists;

  // Saturating count step and expiry test for the tick scan.
  assign cnt_inc   = (ent.count != '1) ? ent.count + COUNT_BITS'(1) : ent.count;
  assign expire    = (CMP_W'(cnt_inc) >= CMP_W'(ent.period));
  assign active    = ent.exists && ent.running;
  assign step_ok   = !(active && expire) || out_free;
  assign scan_last = (scan_q == IDX_W'(NUM_TIMERS - 1));

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          state_d = (action_i == ACT_TICK) ? ST_SCAN : ST_CMD;
        end
      end
      ST_CMD: begin
        if (out_free) state_d = ST_IDLE;
      end
      ST_SCAN: begin
        if (step_ok && scan_last) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // RAM access, scan index and result generation.
  always_comb begin
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_waddr = rd_idx_q;
    ram_raddr = '0;
    ram_wdata = ent;
    scan_d    = scan_q;
    out_load  = 1'b0;
    kind_d    = KIND_STATUS;
    ok_d      = 1'b0;
    tstate_d  = TS_STOPPED;
    rid_d     = id_q;
    last_d    = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          ram_re = 1'b1;
          if (action_i == ACT_TICK) begin
            ram_raddr = '0;
            scan_d    = '0;
          end else begin
            ram_raddr = IDX_W'(timer_id_i);
          end
        end
      end
      ST_CMD: begin
        if (out_free) begin
          out_load = 1'b1;
          unique case (act_q)
            ACT_CREATE: begin
              ok_d   = inb;
              ram_we = inb;
              ram_wdata.exists  = hh_q;
              ram_wdata.running = nst_q;
              ram_wdata.count   = '0;
              ram_wdata.period  = per_q;
            end
            ACT_SET: begin
              ok_d   = ex;
              ram_we = ex;
              ram_wdata.running = nst_q;
            end
            ACT_QUERY: begin
              kind_d   = KIND_STATE;
              ok_d     = ex;
              tstate_d = !ex ? TS_INVALID : (ent.running ? TS_RUNNING : TS_STOPPED);
            end
            ACT_DELETE: begin
              ok_d   = ex;
              ram_we = ex;
              ram_wdata.exists  = 1'b0;
              ram_wdata.running = 1'b0;
              ram_wdata.count   = '0;
            end
            ACT_RESET: begin
              ok_d   = ex;
              ram_we = ex;
              ram_wdata.running = nst_q;
              ram_wdata.count   = '0;
            end
            default: begin
              ok_d = 1'b0;
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (step_ok) begin
          // Count this entry, stop it on expiry.
          if (active) begin
            ram_we            = 1'b1;
            ram_waddr         = scan_q;
            ram_wdata.count   = cnt_inc;
            ram_wdata.running = !expire;
            if (expire) begin
              out_load = 1'b1;
              kind_d   = KIND_EXPIRED;
              ok_d     = 1'b1;
              rid_d    = ID_BITS'(scan_q);
              last_d   = 1'b0;
            end
          end
          // Advance to the next entry.
          if (!scan_last) begin
            ram_re    = 1'b1;
            ram_raddr = scan_q + IDX_W'(1);
            scan_d    = scan_q + IDX_W'(1);
          end
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_load = 1'b1;
          kind_d   = KIND_DONE;
          ok_d     = 1'b1;
          rid_d    = '0;
        end
      end
      default: begin
        out_load = 1'b0;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      valid_q     <= '0;
      out_valid_q <= 1'b0;
      scan_q      <= '0;
      rd_idx_q    <= '0;
    end else begin
      state_q <= state_d;
      scan_q  <= scan_d;
      if (ram_re) rd_idx_q <= ram_raddr;
      if (ram_we) valid_q[ram_waddr] <= 1'b1;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Hold the accepted item.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      act_q <= action_i;
      id_q  <= timer_id_i;
      per_q <= period_i;
      nst_q <= new_state_i;
      hh_q  <= has_handler_i;
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      kind_q   <= kind_d;
      ok_q     <= ok_d;
      tstate_q <= tstate_d;
      rid_q    <= rid_d;
      last_q   <= last_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign kind_o         = kind_q;
  assign ok_o           = ok_q;
  assign timer_state_o  = tstate_q;
  assign timer_id_res_o = rid_q;
  assign last_o         = last_q;

endmodule

// File: hw/rtl/otb_checker.sv
// Port-level checks for the one-shot timer bank, bound to its top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module otb_checker
  import otb_pkg::*;
(
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   in_valid_i,
  input logic                   in_stall_o,
  input logic                   out_valid_o,
  input logic                   out_stall_i,
  input logic [1:0]             kind_o,
  input logic                   ok_o,
  input logic [1:0]             timer_state_o,
  input logic [ID_BITS-1:0]     timer_id_res_o,
  input logic                   last_o
);

  // Whole result payload as one vector.
  logic [ID_BITS+5:0] out_bits;
  assign out_bits = {kind_o, ok_o, timer_state_o, timer_id_res_o, last_o};

  // A stalled result item holds.
  `OTB_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(out_bits))

  // An accepted item keeps the block busy in the next cycle.
  `OTB_ASSERT_NEXT(a_busy_after_accept, in_valid_i && !in_stall_o, in_stall_o)

  // Tick done closes its tick and always succeeds; expiries never close.
  `OTB_ASSERT_NOW(a_done_last, out_valid_o && (kind_o == KIND_DONE), last_o && ok_o && (timer_id_res_o == '0))
  `OTB_ASSERT_NOW(a_expiry_not_last, out_valid_o && (kind_o == KIND_EXPIRED), !last_o && ok_o)

  // Only a state report carries a timer state.
  `OTB_ASSERT_NOW(a_state_only_report, out_valid_o && (kind_o != KIND_STATE), timer_state_o == TS_STOPPED)

endmodule

bind one_shot_timer_bank_core otb_checker u_otb_checker (.*);
